// ===== rtl/udpcs_pkg.sv =====
`default_nettype none

package udpcs_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IndexW = 3;
  localparam int unsigned WideW  = 20;

  // configuration register indexes
  localparam logic [IndexW-1:0] REG_UDP_MODE  = 3'd0;
  localparam logic [IndexW-1:0] REG_SRC_ADDR  = 3'd1;
  localparam logic [IndexW-1:0] REG_DST_ADDR  = 3'd2;
  localparam logic [IndexW-1:0] REG_PROTOCOL  = 3'd3;
  localparam logic [IndexW-1:0] REG_SRC_PORT  = 3'd4;
  localparam logic [IndexW-1:0] REG_DST_PORT  = 3'd5;

  // valid_bytes codes
  localparam logic [1:0] VB_NONE = 2'd0;
  localparam logic [1:0] VB_ONE  = 2'd1;

  localparam logic [7:0]       PROTOCOL_RESET = 8'd17;
  localparam logic [WordW-1:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [WordW-1:0] ALL_ONES       = 16'hffff;

  // settings seen by the datapath
  typedef struct packed {
    logic             udp_mode;
    logic [WordW-1:0] pseudo_sum;
  } cfg_t;

  // two end-around folds bring a sum of up to 16 words back to 16 bits
  function automatic logic [WordW-1:0] oc_fold(input logic [WideW-1:0] a);
    logic [WordW:0] s1;
    logic [WordW:0] s2;
    s1 = {1'b0, a[WordW-1:0]} + {{(WordW+1-(WideW-WordW)){1'b0}}, a[WideW-1:WordW]};
    s2 = {1'b0, s1[WordW-1:0]} + {{WordW{1'b0}}, s1[WordW]};
    return s2[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/udp_ip_ones_complement_checksum.sv =====
`default_nettype none

// channel   ports                                                  role
// in        in_valid, in_stall, in_data_word, in_valid_bytes,      word stream
//           in_last, in_payload_length
// out       out_valid, out_stall, out_checksum_value               one per packet
// cfg       cfg_write_enable, cfg_index, cfg_write_data            register writes
//
// one word per cycle while in_stall is low; a word is held in the input register,
// and a packet's checksum goes from its last word there to the result register.
// the add with end-around carry into the running sum sets the one-cycle rate.
// active-low synchronous reset clears sum, valid flags and cfg; protocol to 17.
// in_stall rises only while a last word waits behind a stalled result.

module udp_ip_ones_complement_checksum (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_enable,
  input  wire logic [udpcs_pkg::IndexW-1:0]   cfg_index,
  input  wire logic [udpcs_pkg::CfgW-1:0]     cfg_write_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [udpcs_pkg::WordW-1:0]    in_data_word,
  input  wire logic [1:0]                     in_valid_bytes,
  input  wire logic                           in_last,
  input  wire logic [udpcs_pkg::WordW-1:0]    in_payload_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [udpcs_pkg::WordW-1:0]         out_checksum_value
);

  udpcs_pkg::cfg_t cfg;

  udpcs_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .cfg_o            (cfg)
  );

  udpcs_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_i              (cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_word       (in_data_word),
    .in_valid_bytes     (in_valid_bytes),
    .in_last            (in_last),
    .in_payload_length  (in_payload_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_checksum_value (out_checksum_value)
  );

endmodule

`default_nettype wire

// ===== rtl/udpcs_cfg.sv =====
`default_nettype none

module udpcs_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_enable,
  input  wire logic [udpcs_pkg::IndexW-1:0]   cfg_index,
  input  wire logic [udpcs_pkg::CfgW-1:0]     cfg_write_data,
  output udpcs_pkg::cfg_t                     cfg_o
);

  logic        udp_mode_r;
  logic [31:0] src_addr_r;
  logic [31:0] dst_addr_r;
  logic [7:0]  protocol_r;
  logic [15:0] source_port_r;
  logic [15:0] dst_port_r;
  logic [15:0] pseudo_sum_r;
  logic [15:0] pseudo_sum_nxt;
  logic [udpcs_pkg::WideW-1:0] wide_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      udp_mode_r    <= 1'b0;
      src_addr_r    <= '0;
      dst_addr_r    <= '0;
      protocol_r    <= udpcs_pkg::PROTOCOL_RESET;
      source_port_r <= '0;
      dst_port_r    <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        udpcs_pkg::REG_UDP_MODE: udp_mode_r <= cfg_write_data[0];
        udpcs_pkg::REG_SRC_ADDR: src_addr_r <= cfg_write_data;
        udpcs_pkg::REG_DST_ADDR: dst_addr_r <= cfg_write_data;
        udpcs_pkg::REG_PROTOCOL: protocol_r <= cfg_write_data[7:0];
        udpcs_pkg::REG_SRC_PORT: source_port_r <= cfg_write_data[15:0];
        udpcs_pkg::REG_DST_PORT: dst_port_r <= cfg_write_data[15:0];
        default: ;
      endcase
    end
  end

  // fixed part of the pseudo-header and udp header, folded ahead of time
  always_comb begin
    wide_sum = {4'b0, src_addr_r[31:16]} + {4'b0, src_addr_r[15:0]}
             + {4'b0, dst_addr_r[31:16]} + {4'b0, dst_addr_r[15:0]}
             + {12'b0, protocol_r}
             + {4'b0, source_port_r} + {4'b0, dst_port_r};
    pseudo_sum_nxt = udpcs_pkg::oc_fold(wide_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pseudo_sum_r <= '0;
    end else begin
      pseudo_sum_r <= pseudo_sum_nxt;
    end
  end

  assign cfg_o.udp_mode   = udp_mode_r;
  assign cfg_o.pseudo_sum = pseudo_sum_r;

endmodule

`default_nettype wire

// ===== rtl/udpcs_core.sv =====
`default_nettype none

module udpcs_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire udpcs_pkg::cfg_t                cfg_i,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [udpcs_pkg::WordW-1:0]    in_data_word,
  input  wire logic [1:0]                     in_valid_bytes,
  input  wire logic                           in_last,
  input  wire logic [udpcs_pkg::WordW-1:0]    in_payload_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [udpcs_pkg::WordW-1:0]         out_checksum_value
);

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] s1_word_r, s1_word_nxt;
  logic        s1_last_r;
  logic [15:0] s1_dbl_r, s1_dbl_nxt;
  logic [15:0] run_r, run_nxt;
  logic        out_v_r, out_v_nxt;
  logic [15:0] out_cs_r, out_cs_nxt;

  logic        in_take;
  logic        s1_go;
  logic        extra_on;
  logic [15:0] udp_len;
  logic [udpcs_pkg::WideW-1:0] wide_sum;
  logic [15:0] sum;
  logic [15:0] inv;

  // a last word waits only while the result register is held
  assign s1_go    = s1_v_r && (!s1_last_r || !out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    case (in_valid_bytes)
      udpcs_pkg::VB_NONE: s1_word_nxt = '0;
      udpcs_pkg::VB_ONE:  s1_word_nxt = {in_data_word[15:8], 8'h00};
      default:            s1_word_nxt = in_data_word;
    endcase
    udp_len = in_payload_length + udpcs_pkg::UDP_HDR_LEN;
    // udp length counted twice: a ones-complement double is a rotate left
    s1_dbl_nxt = {udp_len[14:0], udp_len[15]};
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= s1_word_nxt;
      s1_last_r <= in_last;
      s1_dbl_r  <= s1_dbl_nxt;
    end
  end

  always_comb begin
    extra_on = s1_last_r && cfg_i.udp_mode;
    wide_sum = {4'b0, run_r} + {4'b0, s1_word_r}
             + (extra_on ? {4'b0, cfg_i.pseudo_sum} : '0)
             + (extra_on ? {4'b0, s1_dbl_r} : '0);
    sum = udpcs_pkg::oc_fold(wide_sum);
    inv = ~sum;
    if (cfg_i.udp_mode && inv == '0) begin
      out_cs_nxt = udpcs_pkg::ALL_ONES;
    end else begin
      out_cs_nxt = inv;
    end
    run_nxt   = run_r;
    out_v_nxt = out_v_r && out_stall;
    if (s1_go) begin
      run_nxt = s1_last_r ? '0 : sum;
      if (s1_last_r) begin
        out_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_cs_r <= out_cs_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_checksum_value = out_cs_r;

endmodule

`default_nettype wire

// ===== rtl/udpcs_checker.sv =====
`default_nettype none

module udpcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_checksum_value
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum_value))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // once the result leaves, the input cannot stay stalled
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall outlived the result");

endmodule

bind udp_ip_ones_complement_checksum udpcs_checker u_udpcs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_checksum_value (out_checksum_value)
);

`default_nettype wire
